// ===== rtl/lmlt_pkg.sv =====
// Shared types and constants for the LCD mode and line timing block.
// Used by lmlt_cfg, lmlt_step and lcd_mode_line_timing_core; no dependencies.
package lmlt_pkg;

  localparam int unsigned CfgWidth    = 12;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned DotWidth    = 13;
  localparam int unsigned NumPlain    = 7;

  localparam logic [CfgWidth-1:0] OamResetVal  = 12'd80;
  localparam logic [CfgWidth-1:0] XferResetVal = 12'd172;
  localparam logic [CfgWidth-1:0] HblResetVal  = 12'd204;
  localparam logic [CfgWidth-1:0] LineResetVal = 12'd456;

  localparam logic [7:0] VblankLine = 8'd144;
  localparam logic [7:0] LastLine   = 8'd153;

  // Status and control register bit positions.
  localparam int unsigned StatHblIe  = 3;
  localparam int unsigned StatVblIe  = 4;
  localparam int unsigned StatOamIe  = 5;
  localparam int unsigned StatLycIe  = 6;
  localparam int unsigned CtrlLcdOn  = 7;

  // Register offsets on the bus.
  localparam logic [7:0] OffLcdc = 8'h40;
  localparam logic [7:0] OffStat = 8'h41;
  localparam logic [7:0] OffScy  = 8'h42;
  localparam logic [7:0] OffScx  = 8'h43;
  localparam logic [7:0] OffLy   = 8'h44;
  localparam logic [7:0] OffLyc  = 8'h45;
  localparam logic [7:0] OffBgp  = 8'h47;
  localparam logic [7:0] OffObp0 = 8'h48;
  localparam logic [7:0] OffObp1 = 8'h49;
  localparam logic [7:0] OffWy   = 8'h4A;
  localparam logic [7:0] OffWx   = 8'h4B;

  typedef enum logic [1:0] {
    CFG_OAM_SEARCH = 2'd0,
    CFG_TRANSFER   = 2'd1,
    CFG_HBLANK     = 2'd2,
    CFG_LINE       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CfgWidth-1:0] oam_search;
    logic [CfgWidth-1:0] transfer;
    logic [CfgWidth-1:0] hblank;
    logic [CfgWidth-1:0] line;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                ctrl;
    logic [7:0]                stat;
    logic [7:0]                ly;
    logic [7:0]                lyc;
    logic [NumPlain-1:0][7:0]  plain;
    logic [DotWidth-1:0]       dot;
  } state_t;

  typedef struct packed {
    logic [7:0] line_now;
    logic [1:0] mode_now;
    logic       vblank_irq;
    logic       lcd_irq;
    logic       access_error;
    logic [7:0] read_data;
  } res_t;

endpackage

// ===== rtl/lmlt_cfg.sv =====
// Timing configuration registers of the LCD mode and line timing block.
// Depends on lmlt_pkg for the register layout and reset values.
module lmlt_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lmlt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [lmlt_pkg::CfgWidth-1:0]     cfg_data_i,
  output lmlt_pkg::cfg_t                    cfg_o
);
  import lmlt_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    // Indices beyond the four timing registers are accepted and dropped.
    if (cfg_valid_i && (cfg_index_i[CfgIdxWidth-1:2] == '0)) begin
      case (cfg_idx_e'(cfg_index_i[1:0]))
        CFG_OAM_SEARCH: cfg_d.oam_search = cfg_data_i;
        CFG_TRANSFER:   cfg_d.transfer   = cfg_data_i;
        CFG_HBLANK:     cfg_d.hblank     = cfg_data_i;
        CFG_LINE:       cfg_d.line       = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oam_search <= OamResetVal;
      cfg_q.transfer   <= XferResetVal;
      cfg_q.hblank     <= HblResetVal;
      cfg_q.line       <= LineResetVal;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lmlt_step.sv =====
// Next-state and result logic for one word: a tick of the dot counter or a
// register file access. Purely combinational; depends on lmlt_pkg.
module lmlt_step (
  input  logic [1:0]        kind_i,
  input  logic [7:0]        cycles_i,
  input  logic [7:0]        reg_offset_i,
  input  logic [7:0]        write_data_i,
  input  lmlt_pkg::cfg_t    cfg_i,
  input  lmlt_pkg::state_t  state_i,
  output lmlt_pkg::state_t  state_o,
  output lmlt_pkg::res_t    res_o
);
  import lmlt_pkg::*;

  logic [DotWidth:0]   dot_sum;
  logic [DotWidth-1:0] dot_new;
  logic [DotWidth:0]   dot_ext;
  logic [DotWidth:0]   t1, t2, t3;
  mode_e               old_mode, new_mode;
  logic                irq_en;
  logic                match;
  logic [7:0]          ly_inc;
  logic                is_wr;
  logic                hit;
  logic [7:0]          rd;

  // Tick datapath, worked out regardless of kind and used only on ticks.
  always_comb begin
    dot_sum  = {1'b0, state_i.dot} + {{(DotWidth-7){1'b0}}, cycles_i};
    dot_new  = dot_sum[DotWidth-1:0];
    dot_ext  = {1'b0, dot_new};
    t1       = {2'b00, cfg_i.oam_search};
    t2       = t1 + {2'b00, cfg_i.transfer};
    t3       = t2 + {2'b00, cfg_i.hblank};
    old_mode = mode_e'(state_i.stat[1:0]);
    if (state_i.ly >= VblankLine) begin
      new_mode = MODE_VBLANK;
    end else if (dot_ext < t1) begin
      new_mode = MODE_SEARCH;
    end else if (dot_ext < t2) begin
      new_mode = MODE_TRANSFER;
    end else if (dot_ext < t3) begin
      new_mode = MODE_HBLANK;
    end else begin
      new_mode = old_mode;
    end
    case (new_mode)
      MODE_HBLANK: irq_en = state_i.stat[StatHblIe];
      MODE_VBLANK: irq_en = state_i.stat[StatVblIe];
      MODE_SEARCH: irq_en = state_i.stat[StatOamIe];
      default:     irq_en = 1'b0;
    endcase
    match  = (state_i.ly == state_i.lyc);
    ly_inc = state_i.ly + 8'd1;
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    is_wr   = (kind_i == KIND_WRITE);
    hit     = 1'b1;
    rd      = '0;
    case (kind_e'(kind_i))
      KIND_TICK: begin
        if (!state_i.ctrl[CtrlLcdOn]) begin
          state_o.dot       = '0;
          state_o.ly        = '0;
          state_o.stat[1:0] = MODE_VBLANK;
        end else begin
          state_o.dot     = dot_new;
          state_o.stat    = {state_i.stat[7:3], match, new_mode};
          res_o.lcd_irq   = ((new_mode != old_mode) && irq_en) ||
                            (match && state_i.stat[StatLycIe]);
          if (dot_new >= {1'b0, cfg_i.line}) begin
            state_o.dot      = '0;
            res_o.vblank_irq = (ly_inc == VblankLine);
            state_o.ly       = (ly_inc > LastLine) ? 8'd0 : ly_inc;
          end
        end
      end
      KIND_WRITE, KIND_READ: begin
        case (reg_offset_i)
          OffLcdc: begin
            rd = state_i.ctrl;
            if (is_wr) state_o.ctrl = write_data_i;
          end
          OffStat: begin
            rd = state_i.stat;
            if (is_wr) state_o.stat = write_data_i;
          end
          OffScy: begin
            rd = state_i.plain[0];
            if (is_wr) state_o.plain[0] = write_data_i;
          end
          OffScx: begin
            rd = state_i.plain[1];
            if (is_wr) state_o.plain[1] = write_data_i;
          end
          OffLy: begin
            rd = state_i.ly;
            if (is_wr) state_o.ly = write_data_i;
          end
          OffLyc: begin
            rd = state_i.lyc;
            if (is_wr) state_o.lyc = write_data_i;
          end
          OffBgp: begin
            rd = state_i.plain[2];
            if (is_wr) state_o.plain[2] = write_data_i;
          end
          OffObp0: begin
            rd = state_i.plain[3];
            if (is_wr) state_o.plain[3] = write_data_i;
          end
          OffObp1: begin
            rd = state_i.plain[4];
            if (is_wr) state_o.plain[4] = write_data_i;
          end
          OffWy: begin
            rd = state_i.plain[5];
            if (is_wr) state_o.plain[5] = write_data_i;
          end
          OffWx: begin
            rd = state_i.plain[6];
            if (is_wr) state_o.plain[6] = write_data_i;
          end
          default: hit = 1'b0;
        endcase
        res_o.access_error = !hit;
        res_o.read_data    = is_wr ? 8'd0 : rd;
      end
      default: begin
        // The spare kind code leaves everything as it is.
        state_o = state_i;
      end
    endcase
    res_o.mode_now = state_o.stat[1:0];
    res_o.line_now = state_o.ly;
  end

endmodule

// ===== rtl/lcd_mode_line_timing_core.sv =====
// LCD mode and line timing core: input register, single-pass step logic,
// result register. Depends on lmlt_pkg, lmlt_cfg and lmlt_step.
// Each accepted word waits in the input register; its result goes into the
// result register once that one is empty or being drained. Throughput: one
// word per cycle unless the result stream stalls; the state feedback through
// lmlt_step is combinational. Reset clears the register file, the dot counter
// and both stage valids, and loads the timing registers with their defaults.
module lcd_mode_line_timing_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lmlt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [lmlt_pkg::CfgWidth-1:0]     cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] cycles, [15:8] reg_offset, [23:16] write_data
  input  logic [23:0]                       s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] read_data, [8] access_error, [9] lcd_irq, [10] vblank_irq,
  // [12:11] mode_now, [20:13] line_now, [23:21] zero
  output logic [23:0]                       m_axis_tdata
);
  import lmlt_pkg::*;

  cfg_t        cfg;
  state_t      state_q, state_d;
  res_t        res;
  logic        in_v_q, in_v_d;
  logic        out_v_q, out_v_d;
  logic [1:0]  kind_q;
  logic [23:0] data_q;
  logic [23:0] tdata_q;
  logic        advance;
  logic        take;

  lmlt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lmlt_step u_step (
    .kind_i       (kind_q),
    .cycles_i     (data_q[7:0]),
    .reg_offset_i (data_q[15:8]),
    .write_data_i (data_q[23:16]),
    .cfg_i        (cfg),
    .state_i      (state_q),
    .state_o      (state_d),
    .res_o        (res)
  );

  // A word moves from the input register into the result register whenever
  // the result register is empty or being drained this cycle.
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (take) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= '0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= s_axis_tuser;
      data_q <= s_axis_tdata;
    end
    if (advance) begin
      tdata_q <= {3'b000, res.line_now, res.mode_now, res.vblank_irq,
                  res.lcd_irq, res.access_error, res.read_data};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;

endmodule
